[sv/mersenne_twister_generator_defines.svh]
// Assertion macros for the mersenne_twister_generator checker.
// Depends on nothing; include by bare file name.
`ifndef MERSENNE_TWISTER_GENERATOR_DEFINES_SVH
`define MERSENNE_TWISTER_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MTG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MTG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

[sv/mtg_pkg.sv]
// Shared constants, sequencer states and tempering function of the MT19937 generator.
// Depends on nothing.
`timescale 1ns / 1ps

package mtg_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int ADDR_W       = $clog2(STATE_WORDS);
    localparam int POS_W        = $clog2(STATE_WORDS + 2);
    localparam int WORD_W       = 32;

    localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(STATE_WORDS - 1);
    localparam logic [ADDR_W-1:0] FAR_OFFSET  = ADDR_W'(TWIST_OFFSET);
    localparam logic [ADDR_W-1:0] FAR_WRAP    = ADDR_W'(STATE_WORDS - TWIST_OFFSET);
    localparam logic [POS_W-1:0]  POS_EMPTY   = POS_W'(STATE_WORDS);
    localparam logic [POS_W-1:0]  POS_UNSEEDED = POS_W'(STATE_WORDS + 1);

    localparam logic [WORD_W-1:0] SEED_MULT    = 32'd1812433253;
    localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;
    localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908b0df;
    localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc60000;

    localparam logic OP_SEED = 1'b0;
    localparam logic OP_DRAW = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED_MUL,
        ST_SEED_ADD,
        ST_TW_PRIME,
        ST_TW_LOAD,
        ST_TW_RD,
        ST_TW_WR,
        ST_DRAW_RD
    } seq_state_t;

    function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] y;
        y = w ^ (w >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

endpackage

[sv/mtg_ram.sv]
// Generic single-write, dual-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module mtg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 624,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr_a,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_a,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

[sv/mersenne_twister_generator.sv]
// MT19937 generator top level: command port, sequencer and datapath around the state RAM.
// Depends on mtg_pkg and mtg_ram.
`timescale 1ns / 1ps

// Command-driven 32-bit MT19937. Raise start with opcode and seed_value while busy is low;
// the beat is taken on that edge and busy stays high until the command is done. A seed
// (opcode 0) fills the state RAM one word at a time through a single 32x32 multiplier and
// adder, and gives no result. A draw (opcode 1) costs one RAM read when words are left; the
// drawn word is tempered on its way to random_word. A draw that finds the 624 words used up
// first regenerates them, a read state and a write state per word on the two-read-port
// state RAM. A draw before any seed first seeds with 5489. Each drawn word appears on
// random_word for exactly one cycle with random_valid high, in the cycle busy drops; the
// receiver cannot stall it and must take it then.
module mersenne_twister_generator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        opcode,
    input  logic [mtg_pkg::WORD_W-1:0]  seed_value,
    output logic [mtg_pkg::WORD_W-1:0]  random_word,
    output logic                        random_valid
);

    import mtg_pkg::*;

    seq_state_t          state_reg, state_next;
    logic [ADDR_W-1:0]   idx_reg, idx_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                auto_reg, auto_next;
    logic [WORD_W-1:0]   prev_reg, prev_next;
    logic [WORD_W-1:0]   prod_reg, prod_next;
    logic [WORD_W-1:0]   cur_reg, cur_next;

    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [WORD_W-1:0]   wr_data;
    logic [ADDR_W-1:0]   rd_addr_a;
    logic [ADDR_W-1:0]   rd_addr_b;
    logic [WORD_W-1:0]   rd_data_a;
    logic [WORD_W-1:0]   rd_data_b;

    logic                accept;
    logic                idx_last;
    logic [ADDR_W-1:0]   idx_succ;
    logic [ADDR_W-1:0]   far_addr;
    logic [WORD_W-1:0]   mix_in;
    logic [WORD_W-1:0]   mult_lo;
    logic [WORD_W-1:0]   twist_y;
    logic [WORD_W-1:0]   twist_v;

    mtg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STATE_WORDS)
    ) u_state_ram (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    assign accept   = start && (state_reg == ST_IDLE);
    assign idx_last = (idx_reg == LAST_ADDR);
    assign idx_succ = idx_last ? '0 : idx_reg + ADDR_W'(1);
    // idx + 397 stays below 1024, so no carry is lost.
    assign far_addr = (idx_reg >= FAR_WRAP) ? idx_reg - FAR_WRAP : idx_reg + FAR_OFFSET;

    // Only the low 32 bits of the product are kept.
    assign mix_in  = prev_reg ^ (prev_reg >> 30);
    assign mult_lo = mix_in * SEED_MULT;

    // cur_reg holds state[k]; port a brings state[k+1], port b state[k+397].
    assign twist_y = {cur_reg[WORD_W-1], rd_data_a[WORD_W-2:0]};
    assign twist_v = rd_data_b ^ (twist_y >> 1) ^ (twist_y[0] ? TWIST_MATRIX : '0);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (opcode == OP_SEED)       state_next = ST_SEED_MUL;
                    else if (pos_reg == POS_UNSEEDED)     state_next = ST_SEED_MUL;
                    else if (pos_reg == POS_EMPTY)        state_next = ST_TW_PRIME;
                    else                                  state_next = ST_DRAW_RD;
                end
            end
            ST_SEED_MUL:
            begin
                if (!idx_last)     state_next = ST_SEED_ADD;
                else if (auto_reg) state_next = ST_TW_PRIME;
                else               state_next = ST_IDLE;
            end
            ST_SEED_ADD: state_next = ST_SEED_MUL;
            ST_TW_PRIME: state_next = ST_TW_LOAD;
            ST_TW_LOAD:  state_next = ST_TW_RD;
            ST_TW_RD:    state_next = ST_TW_WR;
            ST_TW_WR:    state_next = idx_last ? ST_DRAW_RD : ST_TW_RD;
            ST_DRAW_RD:  state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and RAM controls.
    always_comb
    begin
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        auto_next  = auto_reg;
        prev_next  = prev_reg;
        prod_next  = prod_reg;
        cur_next   = cur_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = prev_reg;
        rd_addr_a  = idx_succ;
        rd_addr_b  = far_addr;

        // The draw's RAM read lands in the cycle after ST_DRAW_RD; temper it then.
        if (state_reg == ST_DRAW_RD)
        begin
            rd_addr_a = pos_reg[ADDR_W-1:0];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next  = '0;
                    auto_next = 1'b0;
                    if (opcode == OP_SEED)
                    begin
                        prev_next = seed_value;
                    end
                    else if (pos_reg == POS_UNSEEDED)
                    begin
                        prev_next = DEFAULT_SEED;
                        auto_next = 1'b1;
                    end
                end
            end
            ST_SEED_MUL:
            begin
                wr_en     = 1'b1;
                prod_next = mult_lo;
                if (idx_last)
                begin
                    pos_next = POS_EMPTY;
                end
            end
            ST_SEED_ADD:
            begin
                prev_next = prod_reg + WORD_W'(idx_reg) + WORD_W'(1);
                idx_next  = idx_succ;
            end
            ST_TW_PRIME:
            begin
                rd_addr_a = '0;
                idx_next  = '0;
            end
            ST_TW_LOAD:
            begin
                cur_next = rd_data_a;
            end
            ST_TW_RD:
            begin
                // addresses already point at the successor and far word
            end
            ST_TW_WR:
            begin
                wr_en    = 1'b1;
                wr_data  = twist_v;
                cur_next = rd_data_a;
                idx_next = idx_succ;
                if (idx_last)
                begin
                    pos_next = '0;
                end
            end
            ST_DRAW_RD:
            begin
                pos_next = pos_reg + POS_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    // Drawn word: in the cycle after ST_DRAW_RD the read data is valid.
    logic draw_land_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            pos_reg       <= POS_UNSEEDED;
            auto_reg      <= 1'b0;
            draw_land_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            pos_reg       <= pos_next;
            auto_reg      <= auto_next;
            draw_land_reg <= (state_reg == ST_DRAW_RD);
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg <= prev_next;
        prod_reg <= prod_next;
        cur_reg  <= cur_next;
    end

    // Tempered word goes straight from the registered RAM read.
    assign busy         = (state_reg != ST_IDLE);
    assign random_valid = draw_land_reg;
    assign random_word  = draw_land_reg ? temper(rd_data_a) : '0;

endmodule

[sv/mtg_checker.sv]
// Port-level checker for the MT19937 generator, bound to the top level.
// Depends on mersenne_twister_generator_defines.svh.
`timescale 1ns / 1ps
`include "mersenne_twister_generator_defines.svh"

module mtg_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic random_valid
);

    // A taken command always makes the block busy in the next cycle.
    `MTG_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)

    // A result beat only follows work in progress.
    `MTG_ASSERT_SAME(a_valid_after_busy, clk, rst_n, random_valid, $past(busy))

    // A result beat shows up as the block turns idle.
    `MTG_ASSERT_SAME(a_valid_idle, clk, rst_n, random_valid, !busy)

    // Result beats are single-cycle strobes.
    `MTG_ASSERT_NEXT(a_valid_pulse, clk, rst_n, random_valid, !random_valid)

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (.*);

[tb/testbench.sv]
// Self-checking testbench for the MT19937 command-port generator.
// Depends on mtg_pkg and the mersenne_twister_generator RTL; no files or arguments.
`timescale 1ns / 1ps

module testbench;
    import mtg_pkg::*;

    localparam int          ITEM_TARGET  = 1400;
    localparam int          DRAIN_CYCLES = 2600;
    localparam longint      CYCLE_LIMIT  = 8_000_000;
    localparam logic [31:0] MSB_KEEP     = 32'h8000_0000;
    localparam logic [31:0] LOW31_KEEP   = 32'h7fff_ffff;

    typedef struct packed {
        logic        op;
        logic [31:0] seed;
        logic        has_known;
        logic [31:0] known;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 19;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        opcode;
    logic [31:0] seed_value;
    logic [31:0] random_word;
    logic        random_valid;

    // Generator state mirrored by the predictor
    logic [31:0] mt_state [0:STATE_WORDS-1];
    int unsigned mt_pos;

    logic [31:0] pending_words [$];
    int          mismatch_count;
    int          items_sent;
    int          burst_left;
    longint      cycle_count;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{OP_DRAW, 32'h0000_0000, 1'b1, 32'd3499211612},  // unseeded: falls back to 5489
        '{OP_DRAW, 32'hffff_ffff, 1'b1, 32'd581869302},
        '{OP_SEED, 32'h0000_0000, 1'b0, 32'h0},
        '{OP_DRAW, 32'h0000_0000, 1'b1, 32'd2357136044},
        '{OP_SEED, 32'h0000_0001, 1'b0, 32'h0},
        '{OP_DRAW, 32'h0000_0000, 1'b1, 32'd1791095845},
        '{OP_SEED, 32'hffff_ffff, 1'b0, 32'h0},
        '{OP_DRAW, 32'h0000_0000, 1'b0, 32'h0},
        '{OP_DRAW, 32'hffff_ffff, 1'b0, 32'h0},
        '{OP_SEED, 32'd5489,      1'b0, 32'h0},
        '{OP_DRAW, 32'h0000_0000, 1'b1, 32'd3499211612},
        '{OP_SEED, 32'h8000_0000, 1'b0, 32'h0},
        '{OP_SEED, 32'h7fff_ffff, 1'b0, 32'h0},  // back-to-back seeds: second one wins
        '{OP_DRAW, 32'h0000_0000, 1'b0, 32'h0},
        '{OP_DRAW, 32'hffff_ffff, 1'b0, 32'h0},
        '{OP_SEED, 32'haaaa_aaaa, 1'b0, 32'h0},
        '{OP_DRAW, 32'h5555_5555, 1'b0, 32'h0},
        '{OP_SEED, 32'h5555_5555, 1'b0, 32'h0},
        '{OP_DRAW, 32'haaaa_aaaa, 1'b0, 32'h0}
    };

    mersenne_twister_generator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .opcode       (opcode),
        .seed_value   (seed_value),
        .random_word  (random_word),
        .random_valid (random_valid)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void mt_reseed(input logic [31:0] seed);
        logic [31:0] prev;
        mt_state[0] = seed;
        for (int i = 1; i < STATE_WORDS; i++)
        begin
            prev        = mt_state[i-1];
            mt_state[i] = SEED_MULT * (prev ^ (prev >> 30)) + 32'(i);
        end
        mt_pos = STATE_WORDS;
    endfunction

    function automatic void mt_regenerate();
        logic [31:0] y;
        logic [31:0] v;
        for (int k = 0; k < STATE_WORDS; k++)
        begin
            y = (mt_state[k] & MSB_KEEP) | (mt_state[(k + 1) % STATE_WORDS] & LOW31_KEEP);
            v = mt_state[(k + TWIST_OFFSET) % STATE_WORDS] ^ (y >> 1);
            if (y[0])
                v = v ^ TWIST_MATRIX;
            mt_state[k] = v;
        end
        mt_pos = 0;
    endfunction

    function automatic logic [31:0] mt_next_word();
        logic [31:0] y;
        if (mt_pos >= STATE_WORDS)
        begin
            if (mt_pos == STATE_WORDS + 1)
                mt_reseed(DEFAULT_SEED);
            mt_regenerate();
        end
        y      = mt_state[mt_pos];
        mt_pos = mt_pos + 1;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & TEMPER_B);
        y = y ^ ((y << 15) & TEMPER_C);
        y = y ^ (y >> 18);
        return y;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Drive one command beat, wait for it to be taken, then predict its result.
    task automatic send_command(input logic op, input logic [31:0] seed,
                                input logic has_known, input logic [31:0] known);
        logic [31:0] predicted;
        int          gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 64);
        end
        start      <= 1'b1;
        opcode     <= op;
        seed_value <= seed;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        burst_left--;
        items_sent++;
        if (op == OP_SEED)
            mt_reseed(seed);
        else
        begin
            predicted = mt_next_word();
            pending_words.push_back(has_known ? known : predicted);
        end
    endtask

    task automatic send_draws(input int count);
        for (int i = 0; i < count && items_sent < ITEM_TARGET + DIRECTED_ROWS; i++)
            send_command(OP_DRAW, $urandom, 1'b0, 32'h0);
    endtask

    function automatic logic [31:0] pick_seed();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        int kind;
        rst_n          <= 1'b0;
        start          <= 1'b0;
        opcode         <= OP_SEED;
        seed_value     <= 32'h0;
        mismatch_count  = 0;
        items_sent      = 0;
        burst_left      = 0;
        mt_pos          = STATE_WORDS + 1;
        for (int i = 0; i < STATE_WORDS; i++)
            mt_state[i] = 32'h0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            send_command(directed_rows[r].op, directed_rows[r].seed,
                         directed_rows[r].has_known, directed_rows[r].known);

        // Run one sequence well past the end of the state so a second regeneration occurs
        send_command(OP_SEED, pick_seed(), 1'b0, 32'h0);
        send_draws($urandom_range(630, 700));

        while (items_sent < ITEM_TARGET + DIRECTED_ROWS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 6)
                send_command(OP_SEED, pick_seed(), 1'b0, 32'h0);  // seed with no draws
            else if (kind < 12)
                send_draws($urandom_range(1, 20));                 // keep drawing, no reseed
            else if (kind < 16)
            begin
                send_command(OP_SEED, pick_seed(), 1'b0, 32'h0);
                send_draws($urandom_range(600, 680));
            end
            else
            begin
                send_command(OP_SEED, pick_seed(), 1'b0, 32'h0);
                send_draws($urandom_range(1, 60));
            end
        end

        start <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        // A trailing seed gives no result; let it finish before closing
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        logic [31:0] want;
        if (rst_n && random_valid === 1'b1)
        begin
            if (pending_words.size() == 0)
                report_mismatch($sformatf("random_word %08h with no draw pending", random_word));
            else
            begin
                want = pending_words.pop_front();
                if (random_word !== want)
                    report_mismatch($sformatf("random_word %08h, want %08h",
                                              random_word, want));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        cycle_count = 0;
    end

endmodule
